// ----- hdl/dpd_pkg.sv -----
package dpd_pkg;

   localparam int unsigned PAYLOAD_DEPTH_DEF = 64;

   localparam logic [7:0] START0   = 8'hED;
   localparam logic [7:0] START1   = 8'h8C;
   localparam logic [7:0] END_MARK = 8'h8D;
   localparam logic [7:0] BYTE_MASK = 8'hFF;

   localparam int unsigned BYTE_W  = 8;
   localparam int unsigned INDEX_W = 6;
   localparam int unsigned COUNT_W = 7;
   localparam int unsigned FRAME_W = 16;
   localparam int unsigned RSP_W   = 32;

   localparam logic [2:0] PH_SD0  = 3'd0;
   localparam logic [2:0] PH_SD1  = 3'd1;
   localparam logic [2:0] PH_LEN  = 3'd2;
   localparam logic [2:0] PH_DATA = 3'd3;
   localparam logic [2:0] PH_SUM  = 3'd4;
   localparam logic [2:0] PH_END  = 3'd5;
   localparam logic [2:0] PH_RD   = 3'd6;
   localparam logic [2:0] PH_SHOW = 3'd7;

endpackage

// ----- hdl/delimited_packet_deframer.sv -----
// Delimited packet deframer.
// The req channel carries one received link byte per beat. Frames are
// 0xED 0x8C LEN payload[LEN] CHECKSUM 0x8D; LEN + payload + checksum must
// sum to zero modulo 256 and LEN must lie in 1..PAYLOAD_DEPTH.
// Anything malformed is dropped silently and the block hunts for 0xED again.
// Header, payload, checksum and end bytes are accepted without stalling.
// After a good end byte the payload held in the internal byte memory is
// sent on the rsp channel, one beat per byte with its index, the running
// good-frame count and tlast on the final byte. The first rsp beat is
// offered after the end byte is accepted, once the PH_RD state has loaded
// the memory read data register; the following beats come one per cycle
// while rsp_tready is high, since the next memory read is issued in the
// cycle that the current beat is taken. req_tready is low in PH_RD and
// PH_SHOW, the whole drain. A stall on rsp_tready simply holds the current beat and
// the memory read data register. Synchronous reset returns the receiver to
// hunting for 0xED with the frame counter at zero; the payload memory is
// not cleared, as only bytes written by the current frame are ever sent.
module delimited_packet_deframer #(
   parameter int unsigned PAYLOAD_DEPTH = dpd_pkg::PAYLOAD_DEPTH_DEF
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_tvalid,
   output logic                      req_tready,
   input  logic [dpd_pkg::BYTE_W-1:0] req_tdata,  // [7:0] rx_byte
   output logic                      rsp_tvalid,
   input  logic                      rsp_tready,
   output logic [dpd_pkg::RSP_W-1:0] rsp_tdata,   // [7:0] payload_byte,
                                                  // [13:8] byte_index,
                                                  // [29:14] good_frames, [31:30] 0
   output logic                      rsp_tlast    // last_byte
);
   import dpd_pkg::*;

   localparam int unsigned AW = (PAYLOAD_DEPTH > 1) ? $clog2(PAYLOAD_DEPTH) : 1;
   localparam logic [BYTE_W-1:0] DEPTH_B = BYTE_W'(PAYLOAD_DEPTH);

   logic [2:0]         phase_ff, phase_in;
   logic [COUNT_W-1:0] left_ff, left_in;
   logic [BYTE_W-1:0]  sum_ff, sum_in;
   logic [COUNT_W-1:0] count_ff, count_in;
   logic [FRAME_W-1:0] frames_ff, frames_in;
   logic [INDEX_W-1:0] idx_ff, idx_in;
   logic [BYTE_W-1:0]  mem_q_ff;

   logic [BYTE_W-1:0]  mem [PAYLOAD_DEPTH];

   logic               req_beat, rsp_beat, last;
   logic               wr_en, rd_en;
   logic [BYTE_W-1:0]  b;
   logic [BYTE_W-1:0]  sum_add;

   assign b          = req_tdata & BYTE_MASK;
   assign req_tready = (phase_ff != PH_RD) && (phase_ff != PH_SHOW);
   assign req_beat   = req_tvalid && req_tready;
   assign rsp_tvalid = (phase_ff == PH_SHOW);
   assign rsp_beat   = rsp_tvalid && rsp_tready;
   assign last       = (COUNT_W'({1'b0, idx_ff}) + COUNT_W'(1)) == count_ff;
   assign sum_add    = sum_ff + b;

   assign rsp_tlast = last;
   assign rsp_tdata = {2'b00, frames_ff, idx_ff, mem_q_ff};

   always_comb begin
      phase_in  = phase_ff;
      left_in   = left_ff;
      sum_in    = sum_ff;
      count_in  = count_ff;
      frames_in = frames_ff;
      idx_in    = idx_ff;
      wr_en     = 1'b0;
      rd_en     = 1'b0;
      case (phase_ff)
         PH_SD0: begin
            if (req_beat && b == START0) begin
               phase_in = PH_SD1;
               count_in = '0;
            end
         end
         PH_SD1: begin
            if (req_beat) begin
               phase_in = (b == START1) ? PH_LEN : PH_SD0;
            end
         end
         PH_LEN: begin
            if (req_beat) begin
               if (b == '0 || b > DEPTH_B) begin
                  phase_in = PH_SD0;
               end else begin
                  sum_in   = b;
                  left_in  = b[COUNT_W-1:0];
                  phase_in = PH_DATA;
               end
            end
         end
         PH_DATA: begin
            if (req_beat) begin
               if (count_ff < COUNT_W'(PAYLOAD_DEPTH)) begin
                  wr_en    = 1'b1;
                  count_in = count_ff + COUNT_W'(1);
               end
               sum_in  = sum_add;
               left_in = left_ff - COUNT_W'(1);
               if (left_in == '0) begin
                  phase_in = PH_SUM;
               end
            end
         end
         PH_SUM: begin
            if (req_beat) begin
               sum_in   = sum_add;
               phase_in = (sum_add == '0) ? PH_END : PH_SD0;
            end
         end
         PH_END: begin
            if (req_beat) begin
               if (b == END_MARK) begin
                  frames_in = frames_ff + FRAME_W'(1);
                  phase_in  = PH_RD;
               end else begin
                  phase_in = PH_SD0;
               end
            end
         end
         PH_RD: begin
            idx_in   = '0;
            rd_en    = 1'b1;
            phase_in = PH_SHOW;
         end
         PH_SHOW: begin
            if (rsp_beat) begin
               if (last) begin
                  phase_in = PH_SD0;
               end else begin
                  idx_in = idx_ff + INDEX_W'(1);
                  rd_en  = 1'b1;
               end
            end
         end
         default: begin
            phase_in = PH_SD0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff  <= PH_SD0;
         left_ff   <= '0;
         sum_ff    <= '0;
         count_ff  <= '0;
         frames_ff <= '0;
      end else begin
         phase_ff  <= phase_in;
         left_ff   <= left_in;
         sum_ff    <= sum_in;
         count_ff  <= count_in;
         frames_ff <= frames_in;
      end
   end

   always_ff @(posedge clock) begin
      idx_ff <= idx_in;
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[AW'(count_ff)] <= b;
      end
      if (rd_en) begin
         mem_q_ff <= mem[AW'(idx_in)];
      end
   end

`ifndef SYNTHESIS
   a_no_overlap: assert property (@(posedge clock) disable iff (reset)
      !(req_tready && rsp_tvalid))
      else $error("input taken while draining payload");

   a_last_ends: assert property (@(posedge clock) disable iff (reset)
      (rsp_beat && rsp_tlast) |=> !rsp_tvalid)
      else $error("beat after last payload byte");

   a_index_step: assert property (@(posedge clock) disable iff (reset)
      (rsp_beat && !rsp_tlast) |=>
         (rsp_tvalid && rsp_tdata[13:8] == $past(rsp_tdata[13:8]) + INDEX_W'(1)))
      else $error("payload index did not advance by one");

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= COUNT_W'(PAYLOAD_DEPTH))
      else $error("stored count beyond payload depth");

   a_first_index: assert property (@(posedge clock) disable iff (reset)
      (phase_ff == PH_RD) |=> (rsp_tvalid && rsp_tdata[13:8] == '0))
      else $error("drain did not start at index zero");
`endif

endmodule
